>>> src/lsfp_pkg.sv
// Shared constants and types for the lidar scan frame parser.
package lsfp_pkg;

  localparam int unsigned MAX_SAMPLES_DEF = 64;
  localparam int unsigned RING_POINTS_DEF = 512;
  localparam logic [15:0] HEADER_RESET = 16'h55AA;
  localparam logic [17:0] HALF_TURN_Q6 = 18'd11520;

  // Divider widths: |diff| (15 bits) times index (up to 63) plus half divisor
  localparam int unsigned NUM_W = 22;
  localparam int unsigned DEN_W = 7;

  // Parse phases
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_COUNT   = 3'd2;
  localparam logic [2:0] PH_START   = 3'd3;
  localparam logic [2:0] PH_END     = 3'd4;
  localparam logic [2:0] PH_SAMPLES = 3'd5;
  localparam logic [2:0] PH_CHECK   = 3'd6;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

>>> src/lsfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsfp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/lsfp_div.sv
// Restoring divider, one quotient bit per cycle.
module lsfp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lsfp_pkg::div_req_t req,
  output lsfp_pkg::div_rsp_t rsp
);

  localparam int unsigned NW = lsfp_pkg::NUM_W;
  localparam int unsigned DW = lsfp_pkg::DEN_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] step_r, step_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;
  logic          fits;

  // One restoring step
  always_comb begin
    trial    = {rem_r, quo_r[NW-1]};
    fits     = trial >= {1'b0, den_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.num;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      quo_nxt  = {quo_r[NW-2:0], fits};
      step_nxt = step_r + 1'b1;
      if (step_r == CW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (req.start) begin
      den_r <= req.den;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

>>> src/lidar_scan_frame_parser_core.sv
// Lidar scan frame parser: byte parser, XOR check, point emitter.
// Throughput: one byte request per cycle while parsing (in_tready high).
// A frame whose checksum matches releases its points; each point waits on
// the shared 22-step divider that interpolates the angle.
// in_tready is low while points are produced; the last point may wait in the
// output register while parsing resumes. Synchronous active-low reset.
module lidar_scan_frame_parser_core #(
  parameter int unsigned MAX_SAMPLES = lsfp_pkg::MAX_SAMPLES_DEF,
  parameter int unsigned RING_POINTS = lsfp_pkg::RING_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // header_word
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // angle_q6[15:0], distance_raw[31:16], intensity[32], point_slot[41:33]
  output logic [47:0] out_tdata,
  output logic        out_tlast     // last_point
);

  localparam int unsigned AW = $clog2(MAX_SAMPLES);
  localparam int unsigned RW = $clog2(RING_POINTS);
  localparam int unsigned SW = (RW > 9) ? RW : 9;
  localparam int unsigned NW = lsfp_pkg::NUM_W;
  localparam int unsigned DW = lsfp_pkg::DEN_W;

  // Emitter states
  localparam logic [1:0] ST_PARSE = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [15:0]   hdr_r;
  logic [2:0]    phase_r, phase_nxt;
  logic [7:0]    bc_r, bc_nxt;
  logic [7:0]    hold_r, hold_nxt;
  logic [7:0]    cnt_r, cnt_nxt;
  logic [15:0]   sa_r, sa_nxt;
  logic [15:0]   ea_r, ea_nxt;
  logic [15:0]   xor_r, xor_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [6:0]    j_r, j_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic [RW-1:0] ring_r, ring_nxt;
  logic          ov_r, ov_nxt;
  logic [47:0]   od_r, od_nxt;
  logic          ol_r, ol_nxt;

  logic          in_acc;
  logic [15:0]   word;
  logic          go_emit;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   rdata;
  logic [7:0]    byte_idx;

  lsfp_pkg::div_req_t dreq;
  lsfp_pkg::div_rsp_t drsp;

  assign in_tready = (st_r == ST_PARSE);
  assign in_acc    = in_tvalid && in_tready;
  assign word      = {in_tdata, hold_r};
  assign byte_idx  = bc_r >> 1;
  assign waddr     = byte_idx[AW-1:0];

  // Frame parser
  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    hold_nxt  = hold_r;
    cnt_nxt   = cnt_r;
    sa_nxt    = sa_r;
    ea_nxt    = ea_r;
    xor_nxt   = xor_r;
    go_emit   = 1'b0;
    we        = 1'b0;
    if (in_acc) begin
      case (phase_r)
        lsfp_pkg::PH_HUNT: begin
          if (bc_r != 8'd0 && word == hdr_r) begin
            xor_nxt   = hdr_r;
            phase_nxt = lsfp_pkg::PH_TYPE;
            bc_nxt    = 8'd0;
          end else begin
            hold_nxt = in_tdata;
            bc_nxt   = 8'd1;
          end
        end
        lsfp_pkg::PH_TYPE: begin
          hold_nxt  = in_tdata;
          phase_nxt = lsfp_pkg::PH_COUNT;
        end
        lsfp_pkg::PH_COUNT: begin
          xor_nxt = xor_r ^ word;
          cnt_nxt = in_tdata;
          if ({1'b0, in_tdata} > 9'(MAX_SAMPLES)) begin
            phase_nxt = lsfp_pkg::PH_HUNT;
            bc_nxt    = 8'd0;
            hold_nxt  = 8'd0;
          end else begin
            phase_nxt = lsfp_pkg::PH_START;
            bc_nxt    = 8'd0;
          end
        end
        lsfp_pkg::PH_START, lsfp_pkg::PH_END, lsfp_pkg::PH_SAMPLES,
        lsfp_pkg::PH_CHECK: begin
          if (bc_r == 8'd0 || (phase_r == lsfp_pkg::PH_SAMPLES && !bc_r[0])) begin
            hold_nxt = in_tdata;
            bc_nxt   = bc_r + 8'd1;
          end else if (phase_r == lsfp_pkg::PH_START) begin
            sa_nxt    = word;
            xor_nxt   = xor_r ^ word;
            phase_nxt = lsfp_pkg::PH_END;
            bc_nxt    = 8'd0;
          end else if (phase_r == lsfp_pkg::PH_END) begin
            ea_nxt    = word;
            xor_nxt   = xor_r ^ word;
            phase_nxt = (cnt_r == 8'd0) ? lsfp_pkg::PH_CHECK : lsfp_pkg::PH_SAMPLES;
            bc_nxt    = 8'd0;
          end else if (phase_r == lsfp_pkg::PH_SAMPLES) begin
            we      = 1'b1;
            xor_nxt = xor_r ^ word;
            bc_nxt  = bc_r + 8'd1;
            if (((bc_r + 8'd1) >> 1) >= cnt_r) begin
              phase_nxt = lsfp_pkg::PH_CHECK;
              bc_nxt    = 8'd0;
            end
          end else begin
            go_emit   = (word == xor_r) && (cnt_r != 8'd0);
            phase_nxt = lsfp_pkg::PH_HUNT;
            bc_nxt    = 8'd0;
            hold_nxt  = 8'd0;
          end
        end
        default: begin
          phase_nxt = lsfp_pkg::PH_HUNT;
          bc_nxt    = 8'd0;
          hold_nxt  = 8'd0;
        end
      endcase
    end
  end

  lsfp_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (word),
    .raddr (j_r[AW-1:0]),
    .rdata (rdata)
  );

  // Interpolation terms
  logic          multi;
  logic [14:0]   s_ang, e_ang;
  logic          dneg;
  logic [14:0]   dmag;
  logic [DW-1:0] den;
  logic [17:0]   qs, ang;
  logic [SW-1:0] slot_ext;
  logic          is_last;
  logic          out_free;

  always_comb begin
    multi    = cnt_r > 8'd1;
    s_ang    = sa_r[15:1];
    e_ang    = ea_r[15:1];
    dneg     = multi && (e_ang < s_ang);
    dmag     = !multi ? 15'd0 : (dneg ? (s_ang - e_ang) : (e_ang - s_ang));
    den      = multi ? DW'(cnt_r - 8'd1) : DW'(1);
    qs       = dneg ? (18'd0 - {1'b0, drsp.quot[16:0]}) : {1'b0, drsp.quot[16:0]};
    ang      = {3'd0, s_ang} + qs - lsfp_pkg::HALF_TURN_Q6;
    slot_ext = SW'(ring_r);
    is_last  = ({1'b0, j_r} == (cnt_r - 8'd1));
    out_free = !ov_r || out_tready;
    dreq.start = (st_r == ST_START);
    dreq.num   = acc_r + NW'(den >> 1);
    dreq.den   = den;
  end

  lsfp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // Point emitter sequencer and output register
  always_comb begin
    st_nxt   = st_r;
    j_nxt    = j_r;
    acc_nxt  = acc_r;
    ring_nxt = ring_r;
    ov_nxt   = ov_r && !out_tready;
    od_nxt   = od_r;
    ol_nxt   = ol_r;
    case (st_r)
      ST_PARSE: begin
        if (go_emit) begin
          st_nxt  = ST_START;
          j_nxt   = 7'd0;
          acc_nxt = '0;
        end
      end
      ST_START: st_nxt = ST_WAIT;
      ST_WAIT: begin
        if (drsp.done) begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          od_nxt   = {6'd0, slot_ext[8:0], rdata[0], rdata, ang[15:0]};
          ol_nxt   = is_last;
          ring_nxt = (ring_r == RW'(RING_POINTS - 1)) ? '0 : ring_r + 1'b1;
          acc_nxt  = acc_r + NW'(dmag);
          j_nxt    = j_r + 7'd1;
          st_nxt   = is_last ? ST_PARSE : ST_START;
        end
      end
      default: st_nxt = ST_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r   <= lsfp_pkg::HEADER_RESET;
      phase_r <= lsfp_pkg::PH_HUNT;
      bc_r    <= 8'd0;
      hold_r  <= 8'd0;
      cnt_r   <= 8'd0;
      sa_r    <= 16'd0;
      ea_r    <= 16'd0;
      xor_r   <= 16'd0;
      st_r    <= ST_PARSE;
      j_r     <= 7'd0;
      acc_r   <= '0;
      ring_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        hdr_r <= cfg_wr_data;
      end
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      hold_r  <= hold_nxt;
      cnt_r   <= cnt_nxt;
      sa_r    <= sa_nxt;
      ea_r    <= ea_nxt;
      xor_r   <= xor_nxt;
      st_r    <= st_nxt;
      j_r     <= j_nxt;
      acc_r   <= acc_nxt;
      ring_r  <= ring_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    ol_r <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

endmodule

>>> src/lsfp_checker.sv
// Port-level checks for the frame parser, bound to the top level.
module lsfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        out_tlast
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled point holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled point changed");

  // Intensity is bit 0 of the distance word
  a_intensity: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[32] == out_tdata[16])
    else $error("intensity mismatch");

  // Parsing only resumes once the last point of a frame is in the output register
  a_parse_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && out_tvalid |-> out_tlast)
    else $error("parsing while frame points are pending");

endmodule

bind lidar_scan_frame_parser_core lsfp_checker u_lsfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
